// ===== rtl/core/swpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpp_pkg
// Shared types and constants of the weighted priority pick block.
// ----------------------------------------------------------------------------
package swpp_pkg;

  localparam int MAX_RECORDS_DEF = 16;
  localparam int PRIO_W          = 16;
  localparam int WEIGHT_W        = 16;
  localparam int RAND_W          = 32;
  localparam int INDEX_W         = 4;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 16'hFFFF;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_SUM,
    ST_CHK,
    ST_DIV,
    ST_RUN
  } state_t;

endpackage : swpp_pkg
`default_nettype wire

// ===== rtl/core/swpp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpp_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module swpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : swpp_ram
`default_nettype wire

// ===== rtl/core/swpp_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swpp_mod
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module swpp_mod #(
  parameter int SUM_W = 21
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [swpp_pkg::RAND_W-1:0] dividend,
  input  wire logic [SUM_W-1:0]            divisor,
  output logic                             done,
  output logic      [SUM_W-1:0]            remainder
);

  import swpp_pkg::*;

  localparam int STEP_W = $clog2(RAND_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RAND_W - 1);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [RAND_W-1:0] dvd;
  logic [SUM_W-1:0]  dvs;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;

  assign trial     = {rem, dvd[RAND_W-1]};
  assign diff      = trial - {1'b0, dvs};
  assign ge        = (trial >= {1'b0, dvs});
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dvd <= {dvd[RAND_W-2:0], 1'b0};
    end
  end

endmodule : swpp_mod
`default_nettype wire

// ===== rtl/core/srv_weighted_priority_pick_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srv_weighted_priority_pick_top
// Weighted choice among prioritized records, as used for service records.
//
// A transaction is accepted on a rising edge with start high and busy low.
// With func = load, the record (priority_req, weight) is appended to the
// store; busy stays low and no result follows. Loads beyond MAX_RECORDS
// are dropped. With func = pick, the block raises busy and walks the store
// through the memory read port: once for the lowest priority, once to sum
// the weights at that priority and, unless they sum to zero, once more to
// find the winning record. Between the second and third walk a bit-serial
// modulo unit reduces random_value by the weight sum, one bit per cycle.
// The result of a pick is shown in the cycle in which busy falls. A pick
// on an empty store answers in the next cycle with busy low. Each pick
// produces one result, shown for one cycle with done high; the receiver
// cannot stall it. Each pick empties the store. Reset empties the store
// and returns to idle.
// ----------------------------------------------------------------------------
module srv_weighted_priority_pick_top #(
  parameter int MAX_RECORDS = swpp_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func,
  input  wire logic [swpp_pkg::PRIO_W-1:0]   priority_req,
  input  wire logic [swpp_pkg::WEIGHT_W-1:0] weight,
  input  wire logic [swpp_pkg::RAND_W-1:0]   random_value,
  output logic                               done,
  output logic                               found,
  output logic      [swpp_pkg::INDEX_W-1:0]  chosen_index
);

  import swpp_pkg::*;

  localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W  = WEIGHT_W + $clog2(MAX_RECORDS + 1);
  localparam int REC_W  = PRIO_W + WEIGHT_W;

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [ADDR_W-1:0]   rd_addr, rd_addr_next;
  logic                iss, iss_next;
  logic                dv;
  logic [ADDR_W-1:0]   didx;
  logic [PRIO_W-1:0]   best, best_next;
  logic [SUM_W-1:0]    total, total_next;
  logic [ADDR_W-1:0]   first_idx, first_idx_next;
  logic                first_seen, first_seen_next;
  logic [SUM_W-1:0]    run, run_next;
  logic [SUM_W-1:0]    goal, goal_next;
  logic [RAND_W-1:0]   rnd, rnd_next;
  logic                done_next;
  logic                found_next;
  logic [ADDR_W-1:0]   pick_idx, pick_idx_next;

  logic                wr_en;
  logic [REC_W-1:0]    rd_data;
  logic [PRIO_W-1:0]   q_prio;
  logic [SUM_W-1:0]    q_weight;
  logic [CNT_W-1:0]    last_cnt;
  logic [ADDR_W-1:0]   last_idx;
  logic                pass_end;
  logic [SUM_W-1:0]    run_sum;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_rem;
  logic [INDEX_W+ADDR_W-1:0] idx_ext;

  swpp_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({priority_req, weight}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  swpp_mod #(
    .SUM_W (SUM_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rnd),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign q_prio   = rd_data[REC_W-1:WEIGHT_W];
  assign q_weight = SUM_W'(rd_data[WEIGHT_W-1:0]);
  assign last_cnt = count - CNT_W'(1);
  assign last_idx = last_cnt[ADDR_W-1:0];
  assign pass_end = dv && (didx == last_idx);
  assign run_sum  = run + q_weight;
  assign busy     = (state != ST_IDLE);
  assign idx_ext  = {{INDEX_W{1'b0}}, pick_idx};
  assign chosen_index = idx_ext[INDEX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      iss   <= 1'b0;
      dv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      iss   <= iss_next;
      dv    <= iss;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr    <= rd_addr_next;
    didx       <= rd_addr;
    best       <= best_next;
    total      <= total_next;
    first_idx  <= first_idx_next;
    first_seen <= first_seen_next;
    run        <= run_next;
    goal       <= goal_next;
    rnd        <= rnd_next;
    found      <= found_next;
    pick_idx   <= pick_idx_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_addr_next    = rd_addr;
    iss_next        = iss;
    best_next       = best;
    total_next      = total;
    first_idx_next  = first_idx;
    first_seen_next = first_seen;
    run_next        = run;
    goal_next       = goal;
    rnd_next        = rnd;
    done_next       = 1'b0;
    found_next      = found;
    pick_idx_next   = pick_idx;
    div_start       = 1'b0;
    wr_en           = 1'b0;

    if (iss) begin
      rd_addr_next = rd_addr + ADDR_W'(1);
      if (rd_addr == last_idx) begin
        iss_next = 1'b0;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_LOAD) begin
            if (count < CNT_W'(MAX_RECORDS)) begin
              wr_en      = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end else if (func == FUNC_PICK) begin
            if (count == '0) begin
              done_next     = 1'b1;
              found_next    = 1'b0;
              pick_idx_next = '0;
            end else begin
              state_next   = ST_MIN;
              rd_addr_next = '0;
              iss_next     = 1'b1;
              best_next    = PRIO_NONE;
              rnd_next     = random_value;
            end
          end
        end
      end
      ST_MIN: begin
        if (dv && (q_prio < best)) begin
          best_next = q_prio;
        end
        if (pass_end) begin
          state_next      = ST_SUM;
          rd_addr_next    = '0;
          iss_next        = 1'b1;
          total_next      = '0;
          first_seen_next = 1'b0;
        end
      end
      ST_SUM: begin
        if (dv && (q_prio == best)) begin
          total_next = total + q_weight;
          if (!first_seen) begin
            first_idx_next  = didx;
            first_seen_next = 1'b1;
          end
        end
        if (pass_end) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (total == '0) begin
          state_next    = ST_IDLE;
          done_next     = 1'b1;
          found_next    = 1'b1;
          pick_idx_next = first_idx;
          count_next    = '0;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          goal_next    = div_rem;
          state_next   = ST_RUN;
          rd_addr_next = '0;
          iss_next     = 1'b1;
          run_next     = '0;
        end
      end
      ST_RUN: begin
        if (dv && (q_prio == best)) begin
          run_next = run_sum;
        end
        if (dv && (q_prio == best) && (run_sum > goal)) begin
          state_next    = ST_IDLE;
          done_next     = 1'b1;
          found_next    = 1'b1;
          pick_idx_next = didx;
          count_next    = '0;
          iss_next      = 1'b0;
        end else if (pass_end) begin
          state_next    = ST_IDLE;
          done_next     = 1'b1;
          found_next    = 1'b1;
          pick_idx_next = first_idx;
          count_next    = '0;
          iss_next      = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
        iss_next   = 1'b0;
      end
    endcase
  end

endmodule : srv_weighted_priority_pick_top
`default_nettype wire
